/* rtl/jets_pkg.sv */
package jets_pkg;

  localparam int Q_W        = 32;
  localparam int FRAC_BITS  = 27;
  localparam int C_W        = 29;
  localparam int LIM_W      = 31;
  localparam int PIX_W      = 10;
  localparam int D_W        = 13;
  localparam int MAG_W      = D_W - 1;
  localparam int CNT_W      = 10;
  localparam int ITER_OUT_W = 9;
  localparam int COLOR_W    = 24;
  localparam int INT_W      = 8;
  localparam int TBL_DEPTH  = 1 << CNT_W;

  localparam int IMAGE_WIDTH_DEF  = 1024;
  localparam int IMAGE_HEIGHT_DEF = 1024;
  localparam int ITER_LIMIT_DEF   = 500;
  localparam int NUM_CELLS_DEF    = 4;

  localparam longint unsigned PIX_SCALE   = 300;
  localparam longint unsigned SCALE_INT   = (64'd1 << FRAC_BITS) / PIX_SCALE;
  localparam longint unsigned SCALE_REM   = (64'd1 << FRAC_BITS) % PIX_SCALE;
  localparam int              RECIP_SHIFT = 34;
  localparam longint unsigned RECIP_MUL   =
    ((64'd1 << RECIP_SHIFT) + PIX_SCALE - 1) / PIX_SCALE;
  localparam int SINT_W  = 19;
  localparam int SREM_W  = 8;
  localparam int RMUL_W  = 26;
  localparam int PINT_W  = MAG_W + SINT_W;
  localparam int PREM_W  = MAG_W + SREM_W;
  localparam int PFRAC_W = PREM_W + RMUL_W;

  localparam int INTENSITY_MAX   = 255;
  localparam int INTENSITY_BOUND = 260100;

  localparam logic signed [C_W-1:0] C_REAL_RST = 29'sd105830678;
  localparam logic signed [C_W-1:0] C_IMAG_RST = 29'sd0;
  localparam logic [LIM_W-1:0]      LIMIT_RST  = 31'd309716802;

  typedef enum logic [1:0] {
    REG_C_REAL           = 2'd0,
    REG_C_IMAG           = 2'd1,
    REG_ESCAPE_RADIUS_SQ = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic signed [C_W-1:0] c_re;
    logic signed [C_W-1:0] c_im;
    logic [LIM_W-1:0]      lim;
  } julia_cfg_t;

  typedef struct packed {
    logic                  valid;
    logic                  done;
    logic                  in_set;
    logic [CNT_W-1:0]      count;
    logic signed [Q_W-1:0] re;
    logic signed [Q_W-1:0] im;
  } token_t;

  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [39:0] v);
    logic signed [Q_W-1:0] r;
    r = v[Q_W-1:0];
    if (!v[39] && (v[38:Q_W-1] != '0)) begin
      r = {1'b0, {(Q_W-1){1'b1}}};
    end else if (v[39] && (v[38:Q_W-1] != '1)) begin
      r = {1'b1, {(Q_W-1){1'b0}}};
    end
    return r;
  endfunction

  function automatic logic [TBL_DEPTH*INT_W-1:0] build_intensity_rom();
    logic [TBL_DEPTH*INT_W-1:0] rom;
    int v;
    rom = '0;
    v = INTENSITY_MAX;
    for (int i = 0; i < TBL_DEPTH; i++) begin
      while (v > 0 && v * v * (i + 4) > INTENSITY_BOUND) begin
        v = v - 1;
      end
      rom[i*INT_W +: INT_W] = INT_W'(v);
    end
    return rom;
  endfunction

endpackage

/* rtl/jets_map.sv */
module jets_map
  import jets_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic signed [D_W-1:0] d,
  output logic                  out_valid,
  output logic signed [Q_W-1:0] q
);

  logic [MAG_W-1:0]   mag;
  logic               s1_valid;
  logic               s1_neg;
  logic [PINT_W-1:0]  p_int;
  logic [PFRAC_W-1:0] p_frac;
  logic [Q_W-1:0]     q_mag;

  assign mag = d[D_W-1] ? MAG_W'(-d) : MAG_W'(d);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_neg <= d[D_W-1];
    p_int  <= PINT_W'(mag) * PINT_W'(SINT_W'(SCALE_INT));
    p_frac <= PFRAC_W'(PREM_W'(mag) * PREM_W'(SREM_W'(SCALE_REM)))
              * PFRAC_W'(RMUL_W'(RECIP_MUL));
  end

  assign q_mag = Q_W'(p_int) + Q_W'(p_frac[PFRAC_W-1:RECIP_SHIFT]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    q <= s1_neg ? -$signed(q_mag) : $signed(q_mag);
  end

endmodule

/* rtl/jets_cell.sv */
module jets_cell
  import jets_pkg::*;
#(
  parameter int ITERATION_LIMIT = ITER_LIMIT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  julia_cfg_t cfg,
  input  token_t     tin,
  output token_t     tout
);

  token_t             s1;
  token_t             step;
  logic signed [63:0] rr;
  logic signed [63:0] ii;
  logic signed [63:0] ri;
  logic signed [63:0] diff;
  logic [37:0]        mag;
  logic               escaped;
  logic               stop;
  logic signed [39:0] nr;
  logic signed [39:0] ni;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else begin
      s1 <= tin;
    end
  end

  always_ff @(posedge clk) begin
    rr <= tin.re * tin.re;
    ii <= tin.im * tin.im;
    ri <= tin.re * tin.im;
  end

  always_comb begin
    diff    = rr - ii;
    mag     = {1'b0, rr[63:FRAC_BITS]} + {1'b0, ii[63:FRAC_BITS]};
    escaped = mag >= {7'd0, cfg.lim};
    stop    = s1.done || (s1.count >= CNT_W'(ITERATION_LIMIT)) || escaped;
    nr      = {{3{diff[63]}}, diff[63:FRAC_BITS]} + {{11{cfg.c_re[C_W-1]}}, cfg.c_re};
    ni      = {{2{ri[63]}}, ri[63:FRAC_BITS-1]} + {{11{cfg.c_im[C_W-1]}}, cfg.c_im};
    step    = s1;
    if (!stop) begin
      step.re    = sat_q(nr);
      step.im    = sat_q(ni);
      step.count = s1.count + 1'b1;
    end else if (!s1.done) begin
      step.done   = 1'b1;
      step.in_set = !escaped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tout.valid <= 1'b0;
    end else begin
      tout <= step;
    end
  end

endmodule

/* rtl/julia_escape_time_pixel_unit.sv */
// Julia set escape-time evaluator, one pixel per request.
// Request: pulse start with pixel_x/pixel_y; it is taken at a clock edge where
// start is high and busy is low. busy stays high until the result goes out.
// Result: done is high for exactly one cycle with iterations, inside_set and
// pixel_color valid in that cycle; the receiver cannot stall it.
// Configuration: cfg_valid/cfg_index/cfg_data write c_real, c_imag and
// escape_radius_sq; cfg_ready is always high. Write only while busy is low.
// The start point passes a two-stage mapper, then circulates through a ring
// of NUM_CELLS iteration cells; each cell does one complex square-and-add
// step, registering the multiply and then the combine. busy drops in the
// done cycle, so the next request is taken at the edge ending it.
// One pixel is in flight at a time; the default step limit is 500.
// Reset clears busy, the ring and restores the configuration defaults.
module julia_escape_time_pixel_unit
  import jets_pkg::*;
#(
  parameter int IMAGE_WIDTH     = IMAGE_WIDTH_DEF,
  parameter int IMAGE_HEIGHT    = IMAGE_HEIGHT_DEF,
  parameter int ITERATION_LIMIT = ITER_LIMIT_DEF,
  parameter int NUM_CELLS       = NUM_CELLS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [PIX_W-1:0]      pixel_x,
  input  logic [PIX_W-1:0]      pixel_y,
  output logic                  done,
  output logic [ITER_OUT_W-1:0] iterations,
  output logic                  inside_set,
  output logic [COLOR_W-1:0]    pixel_color,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [LIM_W-1:0]      cfg_data
);

  localparam logic [TBL_DEPTH*INT_W-1:0] INTENSITY_ROM = build_intensity_rom();

  julia_cfg_t            cfg;
  logic                  accept;
  logic                  busy_next;
  logic signed [D_W-1:0] dx;
  logic signed [D_W-1:0] dy;
  logic                  map_valid;
  logic                  map_valid_y;
  logic signed [Q_W-1:0] qx;
  logic signed [Q_W-1:0] qy;
  token_t                load_tok;
  token_t                ring_in  [NUM_CELLS];
  token_t                ring_out [NUM_CELLS];
  logic [NUM_CELLS-1:0]  ring_valid;
  logic                  finish;
  logic [CNT_W-1:0]      iter_q;
  logic                  inside_q;
  logic [INT_W-1:0]      level_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.c_re <= C_REAL_RST;
      cfg.c_im <= C_IMAG_RST;
      cfg.lim  <= LIMIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_C_REAL:           cfg.c_re <= cfg_data[C_W-1:0];
        REG_C_IMAG:           cfg.c_im <= cfg_data[C_W-1:0];
        REG_ESCAPE_RADIUS_SQ: cfg.lim  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign accept = start && !busy;
  assign dx     = D_W'(pixel_x) - D_W'(IMAGE_WIDTH / 2);
  assign dy     = D_W'(IMAGE_HEIGHT / 2) - D_W'(pixel_y);

  jets_map u_map_x (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .d         (dx),
    .out_valid (map_valid),
    .q         (qx)
  );

  jets_map u_map_y (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .d         (dy),
    .out_valid (map_valid_y),
    .q         (qy)
  );

  always_comb begin
    load_tok.valid  = map_valid && map_valid_y;
    load_tok.done   = 1'b0;
    load_tok.in_set = 1'b0;
    load_tok.count  = '0;
    load_tok.re     = qx;
    load_tok.im     = qy;
  end

  // close the ring; drop finished tokens at the seam
  always_comb begin
    ring_in[0] = ring_out[NUM_CELLS-1];
    if (load_tok.valid) begin
      ring_in[0] = load_tok;
    end else if (ring_out[NUM_CELLS-1].done) begin
      ring_in[0].valid = 1'b0;
    end
  end

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    if (k > 0) begin : g_link
      assign ring_in[k] = ring_out[k-1];
    end
    assign ring_valid[k] = ring_out[k].valid;
    jets_cell #(
      .ITERATION_LIMIT (ITERATION_LIMIT)
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .cfg  (cfg),
      .tin  (ring_in[k]),
      .tout (ring_out[k])
    );
  end

  assign finish = ring_out[NUM_CELLS-1].valid && ring_out[NUM_CELLS-1].done;

  always_comb begin
    busy_next = busy;
    if (accept) begin
      busy_next = 1'b1;
    end else if (finish) begin
      busy_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= busy_next;
      done <= finish;
    end
  end

  always_ff @(posedge clk) begin
    iter_q   <= ring_out[NUM_CELLS-1].count;
    inside_q <= ring_out[NUM_CELLS-1].in_set;
    level_q  <= INTENSITY_ROM[ring_out[NUM_CELLS-1].count*INT_W +: INT_W];
  end

  assign iterations  = iter_q[ITER_OUT_W-1:0];
  assign inside_set  = inside_q;
  assign pixel_color = inside_q ? {level_q, 16'd0} : {16'd0, level_q};

`ifndef NO_ASSERTIONS
  a_done_ends_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a pending request");

  a_idle_ring_empty: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (ring_valid == '0) && !load_tok.valid)
    else $error("token left in ring while idle");

  a_single_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0({load_tok.valid, ring_valid}))
    else $error("more than one token in ring");
`endif

endmodule

/* tb/sv/tb.sv */
module tb;
  import jets_pkg::*;

  localparam logic [1:0] REG_UNMAPPED = 2'd3;
  localparam int STEP_LIMIT    = ITER_LIMIT_DEF;
  localparam int HALF_W        = IMAGE_WIDTH_DEF / 2;
  localparam int HALF_H        = IMAGE_HEIGHT_DEF / 2;
  localparam int STALL_LIMIT   = 8000;
  localparam int DRAIN_CYCLES  = 2 * ITER_LIMIT_DEF + 2 * NUM_CELLS_DEF + 100;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_PIXELS  = 83;
  localparam int C_SPAN        = 134217728;

  localparam logic signed [C_W-1:0] C_MIN   = {1'b1, {(C_W-1){1'b0}}};
  localparam logic signed [C_W-1:0] C_MAX   = {1'b0, {(C_W-1){1'b1}}};
  localparam logic [LIM_W-1:0]      LIM_MAX = '1;
  localparam logic [LIM_W-1:0]      LIM_FOUR = 31'd1 << 29;

  typedef struct {
    logic [PIX_W-1:0]      px;
    logic [PIX_W-1:0]      py;
    logic [ITER_OUT_W-1:0] iterations;
    logic                  in_set;
    logic [COLOR_W-1:0]    color;
  } pixel_result_t;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic [PIX_W-1:0]      pixel_x;
  logic [PIX_W-1:0]      pixel_y;
  logic                  done;
  logic [ITER_OUT_W-1:0] iterations;
  logic                  inside_set;
  logic [COLOR_W-1:0]    pixel_color;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [1:0]            cfg_index;
  logic [LIM_W-1:0]      cfg_data;

  logic signed [C_W-1:0] c_re_q = C_REAL_RST;
  logic signed [C_W-1:0] c_im_q = C_IMAG_RST;
  logic [LIM_W-1:0]      lim_q  = LIMIT_RST;

  pixel_result_t pending_pixels[$];
  int            mismatches   = 0;
  int            quiet_cycles = 0;

  julia_escape_time_pixel_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .done       (done),
    .iterations (iterations),
    .inside_set (inside_set),
    .pixel_color(pixel_color),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint clamp_q(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint offset_to_q(input longint d);
    longint mag;
    mag = (d < 0) ? -d : d;
    mag = (mag << FRAC_BITS) / 300;
    return (d < 0) ? -mag : mag;
  endfunction

  function automatic longint energy(input longint re, input longint im);
    return ((re * re) >> FRAC_BITS) + ((im * im) >> FRAC_BITS);
  endfunction

  function automatic logic [INT_W-1:0] shade(input longint steps);
    longint v;
    v = INTENSITY_MAX;
    while (v > 0 && v * v * (steps + 4) > INTENSITY_BOUND) v--;
    return v[INT_W-1:0];
  endfunction

  function automatic pixel_result_t escape_time(input logic [PIX_W-1:0] px,
                                                input logic [PIX_W-1:0] py);
    longint        re;
    longint        im;
    longint        nr;
    longint        ni;
    longint        cr;
    longint        ci;
    longint        lim;
    longint        n;
    logic [7:0]    level;
    pixel_result_t r;
    cr  = longint'(c_re_q);
    ci  = longint'(c_im_q);
    lim = longint'({1'b0, lim_q});
    re  = offset_to_q(longint'({1'b0, px}) - HALF_W);
    im  = offset_to_q(HALF_H - longint'({1'b0, py}));
    n   = 0;
    while (n < STEP_LIMIT && energy(re, im) < lim) begin
      nr = ((re * re - im * im) >>> FRAC_BITS) + cr;
      ni = ((re * im) >>> (FRAC_BITS - 1)) + ci;
      re = clamp_q(nr);
      im = clamp_q(ni);
      n++;
    end
    level        = shade(n);
    r.px         = px;
    r.py         = py;
    r.iterations = n[ITER_OUT_W-1:0];
    r.in_set     = energy(re, im) < lim;
    r.color      = r.in_set ? {level, 16'h0000} : {16'h0000, level};
    return r;
  endfunction

  function automatic logic signed [C_W-1:0] random_c(input int span);
    return C_W'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  task automatic compare_field(input string name, input pixel_result_t want,
                               input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: pixel (%0d,%0d) %s expected %0d actual %0d",
               $time, want.px, want.py, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_results
    pixel_result_t want;
    if (!rst && done) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected result expected none actual iterations %0d color %h",
                 $time, iterations, pixel_color);
        mismatches++;
      end else begin
        want = pending_pixels.pop_front();
        compare_field("iterations", want, want.iterations, iterations);
        compare_field("inside_set", want, want.in_set, inside_set);
        compare_field("pixel_color", want, want.color, pixel_color);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_pixel(input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y,
                            input int gap);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start   <= 1'b1;
    pixel_x <= x;
    pixel_y <= y;
    do @(posedge clk); while (busy);
    pending_pixels.push_back(escape_time(x, y));
  endtask

  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [LIM_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_C_REAL:           c_re_q = data[C_W-1:0];
      REG_C_IMAG:           c_im_q = data[C_W-1:0];
      REG_ESCAPE_RADIUS_SQ: lim_q  = data;
      default: ;
    endcase
  endtask

  task automatic configure(input logic signed [C_W-1:0] cre,
                           input logic signed [C_W-1:0] cim,
                           input logic [LIM_W-1:0] lim);
    drain_results();
    // junk above bit 28 must be dropped by the c registers
    write_reg(REG_C_REAL, {2'($urandom), cre});
    write_reg(REG_C_IMAG, {2'($urandom), cim});
    write_reg(REG_ESCAPE_RADIUS_SQ, lim);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_pixel(10'd0, 10'd0, 0);
    send_pixel(10'd1023, 10'd1023, 0);
    send_pixel(10'd0, 10'd1023, 2);
    send_pixel(10'd1023, 10'd0, 0);
    send_pixel(10'd512, 10'd512, 5);
    send_pixel(10'd511, 10'd511, 0);
    send_pixel(10'd512, 10'd0, 1);
    send_pixel(10'd0, 10'd512, 0);
    send_pixel(10'd341, 10'd682, 3);
    send_pixel(10'd1023, 10'd512, 0);
  endtask

  task automatic test_register_extremes();
    // zero limit: every start point is already outside
    configure(C_REAL_RST, C_IMAG_RST, '0);
    send_pixel(10'd512, 10'd512, 0);
    send_pixel(10'd1023, 10'd0, 0);
    // origin with zero c never moves: runs to the step limit
    configure('0, '0, LIMIT_RST);
    send_pixel(10'd512, 10'd512, 0);
    send_pixel(10'd512, 10'd511, 4);
    // large c and widest limit: real part overflows and saturates
    configure(C_MAX, '0, LIM_MAX);
    send_pixel(10'd925, 10'd512, 0);
    send_pixel(10'd0, 10'd0, 0);
    configure(C_MIN, C_MAX, LIM_MAX);
    send_pixel(10'd512, 10'd512, 1);
    send_pixel(10'd1023, 10'd1023, 0);
    configure(C_MIN, C_MIN, 31'd1);
    send_pixel(10'd512, 10'd512, 0);
  endtask

  task automatic test_unmapped_index();
    drain_results();
    write_reg(REG_UNMAPPED, 31'($urandom));
    write_reg(REG_UNMAPPED, LIM_MAX);
    @(negedge clk);
    cfg_valid <= 1'b0;
    send_pixel(10'd512, 10'd512, 0);
    send_pixel(10'd700, 10'd400, 0);
  endtask

  task automatic test_random_pixels();
    logic signed [C_W-1:0] cre;
    logic signed [C_W-1:0] cim;
    logic [LIM_W-1:0]      lim;
    logic [PIX_W-1:0]      x;
    logic [PIX_W-1:0]      y;
    bit                    idle_on;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase % 4)
        0: begin
          cre = random_c(C_SPAN);
          cim = random_c(C_SPAN);
          lim = LIMIT_RST;
        end
        1: begin
          cre = random_c(C_SPAN / 10 * 8);
          cim = random_c(C_SPAN / 10 * 8);
          lim = 31'($urandom);
        end
        2: begin
          cre = C_W'($urandom);
          cim = C_W'($urandom);
          lim = $urandom_range(0, 1) ? LIM_MAX : 31'($urandom);
        end
        default: begin
          cre = -C_W'(105830678) + random_c(C_SPAN / 16);
          cim = random_c(C_SPAN / 16);
          lim = LIM_FOUR;
        end
      endcase
      configure(cre, cim, lim);
      idle_on = (phase % 3 != 1);
      for (int k = 0; k < PHASE_PIXELS; k++) begin
        // bias part of the pixels toward the center, where orbits run long
        if ($urandom_range(0, 9) < 7) begin
          x = PIX_W'($urandom_range(0, 1023));
          y = PIX_W'($urandom_range(0, 1023));
        end else begin
          x = PIX_W'($urandom_range(312, 712));
          y = PIX_W'($urandom_range(312, 712));
        end
        send_pixel(x, y, idle_on ? int'($urandom_range(0, 6)) : 0);
      end
    end
  endtask

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    pixel_x   = '0;
    pixel_y   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_register_extremes();
    test_unmapped_index();
    test_random_pixels();
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
